/* src/cai_pkg.sv */
// Shared types and constants for the checked integer ALU.
// No dependencies; used by every module of the block.
package cai_pkg;

  localparam int unsigned XLEN = 64;

  typedef enum logic [2:0] {
    MODE_ADD  = 3'd0,
    MODE_SUB  = 3'd1,
    MODE_MUL  = 3'd2,
    MODE_DIV  = 3'd3,
    MODE_MOD  = 3'd4,
    MODE_CAST = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    TRAP_NONE = 2'd0,
    TRAP_DIVZ = 2'd1,
    TRAP_OVF  = 2'd2
  } trap_e;

  // One item as it travels through the chain.
  typedef struct packed {
    logic             valid;
    logic [2:0]       mode;
    logic             wide;
    logic             sgn;
    logic             na;
    logic             nb;
    logic [XLEN-1:0]  x;       // dividend / multiplier, shifted out MSB first
    logic [XLEN-1:0]  mb;
    logic [XLEN-1:0]  rem;
    logic [XLEN-1:0]  quo;
    logic [XLEN-1:0]  acc;
    logic             movf;    // product went past 64 bits
    logic             done;    // result already settled in the first stage
    logic [XLEN-1:0]  res;
    logic [1:0]       trap;
  } lane_t;

endpackage

/* src/cai_pre.sv */
// Decode stage: operand setup, add/sub/cast and early division traps.
// Depends on cai_pkg.
module cai_pre
  import cai_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [2:0]      mode_i,
  input  logic            wide_i,
  input  logic            signed_ops_i,
  input  logic [XLEN-1:0] operand_a_i,
  input  logic [XLEN-1:0] operand_b_i,
  input  logic [2:0]      cast_target_i,
  output lane_t           lane_o
);

  lane_t           lane_d, lane_q;
  logic [XLEN-1:0] a, b, r, ma, mb, limit, smask, umask;
  logic            na, nb, ovf, neg, ok, tsigned;

  always_comb begin
    a = operand_a_i;
    b = operand_b_i;
    if (!wide_i) begin
      a = signed_ops_i ? {{32{a[31]}}, a[31:0]} : {32'd0, a[31:0]};
      b = signed_ops_i ? {{32{b[31]}}, b[31:0]} : {32'd0, b[31:0]};
    end
    na = signed_ops_i & a[XLEN-1];
    nb = signed_ops_i & b[XLEN-1];
    ma = na ? (~a + 64'd1) : a;
    mb = nb ? (~b + 64'd1) : b;
    limit = wide_i ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;

    r = (mode_i == MODE_ADD) ? (a + b) : (a - b);
    if (wide_i) begin
      if (signed_ops_i)
        ovf = (mode_i == MODE_ADD) ? ((a[63] ~^ b[63]) & (a[63] ^ r[63]))
                                   : ((a[63] ^ b[63]) & (a[63] ^ r[63]));
      else
        ovf = (mode_i == MODE_ADD) ? (r < a) : (a < b);
    end else if (signed_ops_i) begin
      ovf = {{32{r[31]}}, r[31:0]} != r;
    end else begin
      ovf = (mode_i == MODE_ADD) ? (r[63:32] != 32'd0) : (a < b);
    end

    // cast range check on the raw 64-bit source
    neg = signed_ops_i & operand_a_i[63];
    tsigned = ~cast_target_i[0];
    case (cast_target_i[2:1])
      2'd0: begin smask = ~64'h7F;        umask = ~64'hFF;        end
      2'd1: begin smask = ~64'h7FFF;      umask = ~64'hFFFF;      end
      2'd2: begin smask = ~64'h7FFF_FFFF; umask = ~64'hFFFF_FFFF; end
      default: begin
        smask = 64'h8000_0000_0000_0000;
        umask = 64'd0;
      end
    endcase
    if (tsigned)
      ok = neg ? ((operand_a_i & smask) == smask) : ((operand_a_i & smask) == 64'd0);
    else
      ok = !neg && ((operand_a_i & umask) == 64'd0);

    lane_d = '0;
    lane_d.valid = valid_i;
    lane_d.mode  = mode_i;
    lane_d.wide  = wide_i;
    lane_d.sgn   = signed_ops_i;
    lane_d.na    = na;
    lane_d.nb    = nb;
    lane_d.x     = ma;
    lane_d.mb    = mb;
    lane_d.done  = 1'b1;
    lane_d.res   = '0;
    lane_d.trap  = TRAP_NONE;
    case (mode_i)
      MODE_ADD, MODE_SUB: begin
        if (ovf) lane_d.trap = TRAP_OVF;
        else     lane_d.res  = r;
      end
      MODE_CAST: begin
        if (ok) lane_d.res  = operand_a_i;
        else    lane_d.trap = TRAP_OVF;
      end
      MODE_MUL: lane_d.done = 1'b0;
      MODE_DIV, MODE_MOD: begin
        if (mb == 64'd0)
          lane_d.trap = TRAP_DIVZ;
        else if (signed_ops_i && na && ma == limit && nb && mb == 64'd1)
          lane_d.trap = TRAP_OVF;
        else
          lane_d.done = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q <= '0;
    end else if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

/* src/cai_cell.sv */
// One chain cell: a restoring-division step and a shift-add multiply step
// on the next operand bit. Depends on cai_pkg.
module cai_cell
  import cai_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  lane_t lane_i,
  output lane_t lane_o
);

  lane_t             lane_d, lane_q;
  logic [XLEN:0]     t;
  logic              ge;
  logic [XLEN+1:0]   s;

  always_comb begin
    lane_d = lane_i;
    t  = {lane_i.rem, lane_i.x[XLEN-1]};
    ge = t >= {1'b0, lane_i.mb};
    lane_d.rem = ge ? XLEN'(t - {1'b0, lane_i.mb}) : t[XLEN-1:0];
    lane_d.quo = {lane_i.quo[XLEN-2:0], ge};
    s = {1'b0, lane_i.acc, 1'b0}
      + {2'b00, (lane_i.x[XLEN-1] ? lane_i.mb : {XLEN{1'b0}})};
    lane_d.acc  = s[XLEN-1:0];
    lane_d.movf = lane_i.movf | (s[XLEN+1:XLEN] != 2'b00);
    lane_d.x    = {lane_i.x[XLEN-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q <= '0;
    end else if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

/* src/cai_post.sv */
// Final stage: sign fix-up of products, quotients and remainders, range check of products,
// output register. Depends on cai_pkg.
module cai_post
  import cai_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  lane_t           lane_i,
  output logic            valid_o,
  output logic [XLEN-1:0] result_o,
  output logic [1:0]      trap_o
);

  logic [XLEN-1:0] res_d, res_q, lo, limit;
  logic [1:0]      trap_d, trap_q;
  logic            valid_q, neg, ok;

  always_comb begin
    res_d  = lane_i.res;
    trap_d = lane_i.trap;
    lo     = lane_i.acc;
    neg    = lane_i.na ^ lane_i.nb;
    limit  = lane_i.wide ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
    ok     = 1'b0;
    if (!lane_i.done) begin
      case (lane_i.mode)
        MODE_MUL: begin
          if (lane_i.sgn)
            ok = !lane_i.movf && ((neg && lo != '0) ? (lo <= limit) : (lo < limit));
          else
            ok = !lane_i.movf && (lane_i.wide || lo[63:32] == 32'd0);
          if (ok) begin
            res_d  = (lane_i.sgn && neg) ? (~lo + 64'd1) : lo;
            trap_d = TRAP_NONE;
          end else begin
            res_d  = '0;
            trap_d = TRAP_OVF;
          end
        end
        MODE_DIV: begin
          res_d  = (lane_i.sgn && neg) ? (~lane_i.quo + 64'd1) : lane_i.quo;
          trap_d = TRAP_NONE;
        end
        MODE_MOD: begin
          res_d  = (lane_i.sgn && lane_i.na) ? (~lane_i.rem + 64'd1) : lane_i.rem;
          trap_d = TRAP_NONE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= lane_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q  <= res_d;
      trap_q <= trap_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;
  assign trap_o   = trap_q;

endmodule

/* src/checked_integer_alu.sv */
// Checked integer ALU, top level: decode stage, 64-cell chain, result stage.
// Depends on cai_pkg, cai_pre, cai_cell and cai_post.
//
// Usage: one item on the s_axis side asks for add, subtract, multiply,
// divide, modulo (32 or 64 bit, signed or unsigned) or a checked cast;
// exactly one item leaves on m_axis with the result and a trap code
// (0 none, 1 division by zero, 2 overflow or out of range, result zero).
// The pipeline has one decode stage, 64 chain cells each taking one
// operand bit for the division and multiply steps, and the output register.
// The chain takes one item per cycle unless the output stalls; items enter
// back to back while others are still in the chain.
// The whole chain moves as one pipeline: when m_axis_tready is low and the
// output register holds an item, every stage holds and s_axis_tready drops
// in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits; the block accepts items in the first cycle
// after reset is released.
module checked_integer_alu
  import cai_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // mode[2:0], wide[3], signed_ops[4], operand_a[68:5], operand_b[132:69],
  // cast_target[135:133]
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result[63:0], trap[65:64], zero fill [71:66]
  output logic [71:0]  m_axis_tdata
);

  localparam int unsigned NCELL = XLEN;

  lane_t           chain [NCELL+1];
  logic            en;
  logic [XLEN-1:0] result;
  logic [1:0]      trap;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  cai_pre u_pre (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (s_axis_tvalid),
    .mode_i        (s_axis_tdata[2:0]),
    .wide_i        (s_axis_tdata[3]),
    .signed_ops_i  (s_axis_tdata[4]),
    .operand_a_i   (s_axis_tdata[68:5]),
    .operand_b_i   (s_axis_tdata[132:69]),
    .cast_target_i (s_axis_tdata[135:133]),
    .lane_o        (chain[0])
  );

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    cai_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .lane_i (chain[g]),
      .lane_o (chain[g+1])
    );
  end

  cai_post u_post (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .lane_i   (chain[NCELL]),
    .valid_o  (m_axis_tvalid),
    .result_o (result),
    .trap_o   (trap)
  );

  assign m_axis_tdata = {6'd0, trap, result};

endmodule

/* verif/tb_checked_integer_alu.sv */
// Testbench for checked_integer_alu: directed corner items, then random items
// with bursty input and stalling output, checked against an in-bench predictor.
// Depends on cai_pkg and the checked_integer_alu RTL.
module tb_checked_integer_alu
  import cai_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] MSB64 = 64'h8000_0000_0000_0000;

  typedef struct {
    logic [63:0] value;
    logic [1:0]  trap;
  } alu_out_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;

  alu_out_t expected_q[$];
  int       errors = 0;
  bit       stall_mode = 1'b0;

  checked_integer_alu u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    forever #4ns clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("checked_integer_alu: mismatch");
    $finish;
  end

  // 128-bit magnitude math keeps the predictor simple
  function automatic alu_out_t predict_alu(logic [2:0] mode, logic wide, logic sgn,
                                           logic [63:0] a, logic [63:0] b,
                                           logic [2:0] tgt);
    alu_out_t    r;
    logic [63:0] ea, eb, ma, mb, lim, umax, q;
    logic        na, nb, neg, ok;
    logic [127:0] prod;
    logic signed [65:0] sres;
    int          tb;
    r.value = '0;
    r.trap = TRAP_NONE;
    if (mode == MODE_CAST) begin
      tb = 8 << tgt[2:1];
      neg = sgn && a[63];
      ma = neg ? -a : a;
      lim = (tb == 64) ? MSB64 : (64'd1 << (tb - 1));
      umax = (tb == 64) ? '1 : ((64'd1 << tb) - 1);
      ok = !tgt[0] ? (neg ? ma <= lim : ma < lim) : (!neg && ma <= umax);
      if (ok) r.value = a;
      else r.trap = TRAP_OVF;
    end else if (mode <= MODE_MOD) begin
      ea = wide ? a : (sgn ? {{32{a[31]}}, a[31:0]} : {32'd0, a[31:0]});
      eb = wide ? b : (sgn ? {{32{b[31]}}, b[31:0]} : {32'd0, b[31:0]});
      na = sgn && ea[63];
      nb = sgn && eb[63];
      ma = na ? -ea : ea;
      mb = nb ? -eb : eb;
      lim = wide ? MSB64 : 64'h8000_0000;
      umax = wide ? '1 : 64'hFFFF_FFFF;
      case (mode)
        MODE_ADD, MODE_SUB: begin
          // exact result in 66 bits, then range check
          if (sgn)
            sres = (mode == MODE_ADD) ? $signed({{2{ea[63]}}, ea}) + $signed({{2{eb[63]}}, eb})
                                      : $signed({{2{ea[63]}}, ea}) - $signed({{2{eb[63]}}, eb});
          else
            sres = (mode == MODE_ADD) ? $signed({2'b0, ea}) + $signed({2'b0, eb})
                                      : $signed({2'b0, ea}) - $signed({2'b0, eb});
          if (sgn)
            ok = wide ? (sres >= -$signed({2'b0, MSB64}) && sres < $signed({2'b0, MSB64}))
                      : (sres >= -66'sd2147483648 && sres <= 66'sd2147483647);
          else
            ok = sres >= 0 && sres <= $signed({2'b0, umax});
          if (ok) r.value = sres[63:0];
          else r.trap = TRAP_OVF;
        end
        MODE_MUL: begin
          prod = {64'd0, ma} * {64'd0, mb};
          neg = (na != nb) && prod != 0;
          if (sgn) ok = prod[127:64] == 0 && (neg ? prod[63:0] <= lim : prod[63:0] < lim);
          else ok = prod[127:64] == 0 && prod[63:0] <= umax;
          if (ok) r.value = (sgn && na != nb) ? -prod[63:0] : prod[63:0];
          else r.trap = TRAP_OVF;
        end
        default: begin
          if (mb == 0) r.trap = TRAP_DIVZ;
          else if (sgn && na && ma == lim && nb && mb == 1) r.trap = TRAP_OVF;
          else if (mode == MODE_DIV) begin
            q = ma / mb;
            r.value = (sgn && na != nb) ? -q : q;
          end else begin
            q = ma % mb;
            r.value = (sgn && na) ? -q : q;
          end
        end
      endcase
    end
    return r;
  endfunction

  task automatic send_op(logic [2:0] mode, logic wide, logic sgn, logic [63:0] a,
                         logic [63:0] b, logic [2:0] tgt);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {tgt, b, a, sgn, wide, mode};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(predict_alu(mode, wide, sgn, a, b, tgt));
  endtask

  // sender gap after a random-length burst
  int burst_left = 0;
  task automatic maybe_gap();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 30);
    gap = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    logic [63:0] picks[8] = '{64'd0, 64'd1, '1, MSB64, MSB64 - 1,
                              64'h8000_0000, 64'h7FFF_FFFF, 64'hFFFF_FFFF};
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = picks[$urandom_range(0, 7)];
      1: v = {{32{v[31]}}, v[31:0]};
      2: v = v >> $urandom_range(0, 63);
      3: v = -(v >> $urandom_range(0, 63));
      default: ;
    endcase
    return v;
  endfunction

  task automatic test_arith_corners();
    logic [63:0] vals[6] = '{64'd0, 64'd1, '1, MSB64, MSB64 - 1, 64'h8000_0000};
    for (int m = MODE_ADD; m <= MODE_MOD; m++)
      for (int k = 0; k < 4; k++)
        send_op(m[2:0], k[0], k[1], vals[(m + k) % 6], vals[(m + 2 * k + 1) % 6], 3'd0);
    send_op(MODE_DIV, 1'b1, 1'b1, MSB64, '1, 3'd0);
    send_op(MODE_MOD, 1'b0, 1'b1, 64'h8000_0000, 64'hFFFF_FFFF, 3'd0);
    send_op(MODE_DIV, 1'b0, 1'b0, 64'h5, 64'hFFFF_FFFF_0000_0000, 3'd0);
    send_op(3'd6, 1'b1, 1'b1, '1, '1, 3'd7);
    send_op(3'd7, 1'b0, 1'b0, '1, '1, 3'd7);
  endtask

  task automatic test_cast_corners();
    logic [63:0] vals[4] = '{64'd127, 64'hFFFF_FFFF_FFFF_FF80, 64'd255, MSB64};
    for (int t = 0; t < 8; t++)
      send_op(MODE_CAST, t[0], t[1], vals[t % 4], '1, t[2:0]);
  endtask

  task automatic test_random(int n);
    logic [2:0] mode;
    for (int i = 0; i < n; i++) begin
      maybe_gap();
      mode = $urandom_range(0, 15) == 0 ? 3'($urandom_range(6, 7))
                                         : 3'($urandom_range(0, 5));
      send_op(mode, 1'($urandom), 1'($urandom), rand64(), rand64(), 3'($urandom));
    end
  endtask

  // result checker; receiver stalls at random in alternating stretches
  always @(posedge clk_i) begin
    alu_out_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result item %h", m_axis_tdata);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (m_axis_tdata[63:0] !== want.value) begin
            $error("result: expected %h, got %h", want.value, m_axis_tdata[63:0]);
            errors++;
          end
          if (m_axis_tdata[65:64] !== want.trap) begin
            $error("trap: expected %0d, got %0d", want.trap, m_axis_tdata[65:64]);
            errors++;
          end
        end
      end
      if ($urandom_range(0, 99) == 0) stall_mode <= ~stall_mode;
      m_axis_tready <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
    end
  end

  initial begin
    int waited;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_arith_corners();
    test_cast_corners();
    test_random(1300);
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (expected_q.size() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (80) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("checked_integer_alu: match");
    end else begin
      $display("checked_integer_alu: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/cai_pkg.sv
src/cai_pre.sv
src/cai_cell.sv
src/cai_post.sv
src/checked_integer_alu.sv
verif/tb_checked_integer_alu.sv
